// File: src/mwwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwwa_pkg
// Shared widths, types and constants of the masked weighted window average.
// ----------------------------------------------------------------------------
package mwwa_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int WEIGHT_W    = 16;
    localparam int PROD_W      = SAMPLE_W + WEIGHT_W + 1;   // signed x {0,unsigned}
    localparam int WSUM_W      = 58;
    localparam int WTOT_W      = 26;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS   = WSUM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // one finished window, waiting for its division
    typedef struct packed {
        logic [WSUM_W-1:0] wsum;
        logic [WTOT_W-1:0] wtot;
    } t_window;

endpackage

// File: src/mwwa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwwa_front
// Takes cell beats, registers weight * sample, accumulates both sums and
// pushes the finished sums of a window into the queue on its last cell.
// ----------------------------------------------------------------------------
module mwwa_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [mwwa_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                               i_sample_missing,
    input  logic        [mwwa_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                               i_last_of_window,
    input  logic        [mwwa_pkg::QCNT_W-1:0] i_q_level,
    output logic                               o_push,
    output mwwa_pkg::t_window                  o_push_data
);

    logic                                r_p_valid, n_p_valid;
    logic                                r_p_last;
    logic signed [mwwa_pkg::PROD_W-1:0]  r_prod;
    logic        [mwwa_pkg::WEIGHT_W-1:0] r_w;
    logic        [mwwa_pkg::WSUM_W-1:0]  r_wsum, n_wsum;
    logic        [mwwa_pkg::WTOT_W-1:0]  r_wtot, n_wtot;

    logic                                w_accept;
    logic signed [mwwa_pkg::PROD_W-1:0]  w_prod;
    logic        [mwwa_pkg::WSUM_W-1:0]  w_sum_add;
    logic        [mwwa_pkg::WTOT_W-1:0]  w_tot_add;
    logic        [mwwa_pkg::QCNT_W:0]    w_committed;

    // queue slots already spoken for: stored windows plus a last cell in flight
    assign w_committed = {1'b0, i_q_level} + {{mwwa_pkg::QCNT_W{1'b0}}, r_p_valid & r_p_last};
    assign busy        = (w_committed >= (mwwa_pkg::QCNT_W + 1)'(mwwa_pkg::QUEUE_DEPTH));
    assign w_accept    = start & ~busy;

    assign w_prod = $signed(i_sample) * $signed({1'b0, i_weight});

    assign w_sum_add = r_wsum + {{(mwwa_pkg::WSUM_W - mwwa_pkg::PROD_W){r_prod[mwwa_pkg::PROD_W-1]}},
                                 r_prod};
    assign w_tot_add = r_wtot + {{(mwwa_pkg::WTOT_W - mwwa_pkg::WEIGHT_W){1'b0}}, r_w};

    always_comb begin
        n_p_valid = w_accept;
        n_wsum    = r_wsum;
        n_wtot    = r_wtot;
        if (r_p_valid) begin
            if (r_p_last) begin
                n_wsum = '0;
                n_wtot = '0;
            end else begin
                n_wsum = w_sum_add;
                n_wtot = w_tot_add;
            end
        end
    end

    assign o_push           = r_p_valid & r_p_last;
    assign o_push_data.wsum = w_sum_add;
    assign o_push_data.wtot = w_tot_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_wsum    <= '0;
            r_wtot    <= '0;
        end else begin
            r_p_valid <= n_p_valid;
            r_wsum    <= n_wsum;
            r_wtot    <= n_wtot;
        end
    end

    // missing cells enter as zero weight and zero product
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_last <= i_last_of_window;
            r_prod   <= i_sample_missing ? '0 : w_prod;
            r_w      <= i_sample_missing ? '0 : i_weight;
        end
    end

endmodule

// File: src/mwwa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwwa_queue
// Small FIFO of finished window sums between accumulator and divider.
// ----------------------------------------------------------------------------
module mwwa_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  mwwa_pkg::t_window             i_push_data,
    input  logic                          i_pop,
    output mwwa_pkg::t_window             o_head,
    output logic                          o_empty,
    output logic [mwwa_pkg::QCNT_W-1:0]   o_level
);

    mwwa_pkg::t_window                 r_slot [mwwa_pkg::QUEUE_DEPTH];
    logic [mwwa_pkg::QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [mwwa_pkg::QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [mwwa_pkg::QCNT_W-1:0]       r_level, n_level;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == mwwa_pkg::QPTR_W'(mwwa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                  : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == mwwa_pkg::QPTR_W'(mwwa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                  : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_level = r_level + 1'b1;
            2'b01:   n_level = r_level - 1'b1;
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

endmodule

// File: src/mwwa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwwa_divider
// Pops one window's sums, divides sign-magnitude with a restoring divider
// (one quotient bit per cycle), saturates to 32 bits and strobes the result.
// ----------------------------------------------------------------------------
module mwwa_divider (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_empty,
    input  mwwa_pkg::t_window                    i_q_head,
    output logic                                 o_pop,
    output logic                                 o_valid,
    output logic signed [mwwa_pkg::SAMPLE_W-1:0] o_average,
    output logic                                 o_average_missing
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [mwwa_pkg::STEP_W-1:0]   r_step, n_step;
    logic                          r_valid, n_valid;
    logic                          r_neg;
    logic                          r_miss;
    logic [mwwa_pkg::WSUM_W-1:0]   r_mag;      // dividend, then quotient
    logic [mwwa_pkg::WTOT_W-1:0]   r_tot;
    logic [mwwa_pkg::WTOT_W-1:0]   r_rem;
    logic [mwwa_pkg::SAMPLE_W-1:0] r_avg;
    logic                          r_avg_miss;

    logic [mwwa_pkg::WSUM_W-1:0]   w_abs;
    logic [mwwa_pkg::WTOT_W:0]     w_rem_sh;
    logic                          w_ge;
    logic [mwwa_pkg::WTOT_W:0]     w_rem_sub;
    logic                          w_pos_ovf;
    logic                          w_neg_ovf;
    logic [mwwa_pkg::SAMPLE_W-1:0] w_sat;

    assign w_abs = i_q_head.wsum[mwwa_pkg::WSUM_W-1] ? (~i_q_head.wsum + 1'b1) : i_q_head.wsum;

    assign w_rem_sh  = {r_rem, r_mag[mwwa_pkg::WSUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_tot});
    assign w_rem_sub = w_rem_sh - {1'b0, r_tot};

    // saturation bounds: +0x7FFFFFFF, -0x80000000
    assign w_pos_ovf = (r_mag[mwwa_pkg::WSUM_W-1:mwwa_pkg::SAMPLE_W-1] != '0);
    assign w_neg_ovf = (r_mag[mwwa_pkg::WSUM_W-1:mwwa_pkg::SAMPLE_W] != '0)
                     || (r_mag[mwwa_pkg::SAMPLE_W-1] && (r_mag[mwwa_pkg::SAMPLE_W-2:0] != '0));

    always_comb begin
        if (r_miss) begin
            w_sat = '0;
        end else if (r_neg) begin
            w_sat = w_neg_ovf ? {1'b1, {(mwwa_pkg::SAMPLE_W-1){1'b0}}}
                              : (~r_mag[mwwa_pkg::SAMPLE_W-1:0] + 1'b1);
        end else begin
            w_sat = w_pos_ovf ? {1'b0, {(mwwa_pkg::SAMPLE_W-1){1'b1}}}
                              : r_mag[mwwa_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_pop = (r_state == ST_IDLE) & ~i_q_empty;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (!i_q_empty) begin
                    n_state = (i_q_head.wtot == '0) ? ST_SAT : ST_DIV;
                end
            end
            ST_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == mwwa_pkg::STEP_W'(mwwa_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg <= i_q_head.wsum[mwwa_pkg::WSUM_W-1];
            r_miss <= (i_q_head.wtot == '0);
            r_mag <= w_abs;
            r_tot <= i_q_head.wtot;
            r_rem <= '0;
        end else if (r_state == ST_DIV) begin
            r_mag <= {r_mag[mwwa_pkg::WSUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[mwwa_pkg::WTOT_W-1:0] : w_rem_sh[mwwa_pkg::WTOT_W-1:0];
        end
        if (r_state == ST_SAT) begin
            r_avg      <= w_sat;
            r_avg_miss <= r_miss;
        end
    end

    assign o_valid           = r_valid;
    assign o_average         = r_avg;
    assign o_average_missing = r_avg_miss;

endmodule

// File: src/masked_weighted_window_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_weighted_window_average
// Weighted mean of one filter window, skipping missing cells.
// Throughput: one cell per cycle while busy is low; a new window enters the
//   58-step restoring divider only when it is idle (two-entry queue absorbs
//   short windows). Last cell: registered, queued, popped, divided (skipped
//   if weight sum is zero), saturated, strobed. Receiver cannot stall.
// Reset: synchronous active low; clears sums, queue and divider, no result.
// ----------------------------------------------------------------------------
module masked_weighted_window_average (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [mwwa_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_sample_missing,
    input  logic        [mwwa_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                                 i_last_of_window,
    output logic                                 o_valid,
    output logic signed [mwwa_pkg::SAMPLE_W-1:0] o_average,
    output logic                                 o_average_missing
);

    logic                          w_push;
    mwwa_pkg::t_window             w_push_data;
    logic                          w_pop;
    mwwa_pkg::t_window             w_head;
    logic                          w_empty;
    logic [mwwa_pkg::QCNT_W-1:0]   w_level;

    mwwa_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_sample         (i_sample),
        .i_sample_missing (i_sample_missing),
        .i_weight         (i_weight),
        .i_last_of_window (i_last_of_window),
        .i_q_level        (w_level),
        .o_push           (w_push),
        .o_push_data      (w_push_data)
    );

    mwwa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_empty     (w_empty),
        .o_level     (w_level)
    );

    mwwa_divider u_divider (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (w_empty),
        .i_q_head          (w_head),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .o_average         (o_average),
        .o_average_missing (o_average_missing)
    );

    // busy must keep the queue from overflowing
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && !w_pop && (w_level == mwwa_pkg::QCNT_W'(mwwa_pkg::QUEUE_DEPTH))))
        else $error("window pushed into full queue");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= mwwa_pkg::QCNT_W'(mwwa_pkg::QUEUE_DEPTH))
        else $error("queue level out of range");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_missing_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_average_missing) |-> (o_average == '0))
        else $error("missing result carries nonzero average");

endmodule
